// ----- rtl/core/bf_pkg.sv -----
package bf_pkg;

	// Bitmap and probe limits
	localparam int MAX_BYTES  = 1024;
	localparam int MAX_PROBES = 8;

	// Derived widths: byte address, bit index (remainder), bit range
	localparam int ADDR_W  = $clog2(MAX_BYTES);
	localparam int REM_W   = ADDR_W + 3;
	localparam int RANGE_W = REM_W + 1;

	// Fixed field and register widths
	localparam int HASH_W     = 32;
	localparam int PROBE_W    = 4;
	localparam int BYTES_W    = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int BIT_CNT_W  = $clog2(HASH_W);

	// Job queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic [HASH_W-1:0] PROBE_ADD = 32'hEDB8_8320;

	localparam logic [PROBE_W-1:0] PROBES_RESET = 4'd2;
	localparam logic [BYTES_W-1:0] BYTES_RESET  = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_PROBES   = 2'd0,
		CFG_FILTER_BYTES = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic              is_test;
		logic [HASH_W-1:0] hash;
	} bf_job_t;

	typedef struct packed {
		logic [PROBE_W-1:0] probes;
		logic [RANGE_W-1:0] range;
	} bf_cfg_t;

	typedef struct packed {
		logic clearing;
	} bf_status_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_HASH,
		BK_DIV,
		BK_READ,
		BK_CHECK,
		BK_FINISH
	} bk_state_t;

	// h * 31 modulo 2^32
	function automatic logic [HASH_W-1:0] mul31(input logic [HASH_W-1:0] h);
		return (h << 5) - h;
	endfunction

endpackage

// ----- rtl/core/bf_ram.sv -----
module bf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/bf_front.sv -----
module bf_front import bf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] value_byte,
	input  logic       has_byte,
	input  logic       last_byte,
	input  logic       func,
	input  bf_status_t status,
	input  logic       q_ready,
	output logic       push,
	output bf_job_t    job
);

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] hash_next;
	logic              accept;

	assign s_tready = !status.clearing && q_ready;
	assign accept   = s_tvalid && s_tready;

	// Fold the byte in as a signed char
	always_comb begin
		hash_next = hash_q;
		if (has_byte) begin
			hash_next = mul31(hash_q) + {{(HASH_W-8){value_byte[7]}}, value_byte};
		end
	end

	assign push        = accept && last_byte;
	assign job.is_test = func;
	assign job.hash    = hash_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			hash_q <= last_byte ? '0 : hash_next;
		end
	end

endmodule

// ----- rtl/core/bf_queue.sv -----
module bf_queue import bf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bf_job_t push_job,
	output logic    q_ready,
	input  logic    pop,
	output logic    q_valid,
	output bf_job_t pop_job
);

	bf_job_t            slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign q_ready = (count_q != (Q_PTR_W+1)'(Q_DEPTH));
	assign q_valid = (count_q != '0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/bf_back.sv -----
module bf_back import bf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bf_cfg_t    cfg,
	input  logic       q_valid,
	input  bf_job_t    q_job,
	output logic       pop,
	output bf_status_t status,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic       answer
);

	bk_state_t          state_q;
	bk_state_t          state_next;

	logic [HASH_W-1:0]  h_q;
	logic [HASH_W-1:0]  dvd_q;
	logic [REM_W-1:0]   rem_q;
	logic [BIT_CNT_W-1:0] bit_q;
	logic [PROBE_W-1:0] probe_cnt_q;
	logic               is_test_q;
	logic               all_set_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               m_tvalid_q;
	logic               answer_q;

	logic [HASH_W-1:0]  h_next;
	logic [RANGE_W-1:0] trial;
	logic               trial_ge;
	logic [RANGE_W-1:0] trial_sub;
	logic               probe_bit;
	logic               last_probe;
	logic               out_load;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [7:0]         ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [7:0]         ram_rdata;

	bf_ram #(
		.WIDTH (8),
		.DEPTH (MAX_BYTES)
	) u_bits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign h_next     = mul31(h_q) + PROBE_ADD;
	assign trial      = {rem_q, dvd_q[HASH_W-1]};
	assign trial_ge   = (trial >= cfg.range);
	assign trial_sub  = trial - cfg.range;
	assign probe_bit  = ram_rdata[rem_q[2:0]];
	assign last_probe = (PROBE_W'(probe_cnt_q + 1'b1) == cfg.probes);
	assign out_load   = !m_tvalid_q || m_tready;

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_addr_q == ADDR_W'(MAX_BYTES - 1)) state_next = BK_IDLE;
			end
			BK_IDLE: begin
				if (q_valid) state_next = (cfg.probes == '0) ? BK_FINISH : BK_HASH;
			end
			BK_HASH:  state_next = BK_DIV;
			BK_DIV: begin
				if (bit_q == BIT_CNT_W'(HASH_W - 1)) state_next = BK_READ;
			end
			BK_READ:  state_next = BK_CHECK;
			BK_CHECK: state_next = last_probe ? BK_FINISH : BK_HASH;
			BK_FINISH: begin
				if (out_load) state_next = BK_IDLE;
			end
			default:  state_next = BK_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = rem_q[REM_W-1:3];
		ram_wdata = ram_rdata | (8'd1 << rem_q[2:0]);
		ram_raddr = rem_q[REM_W-1:3];
		unique case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			BK_IDLE:  pop    = q_valid;
			BK_CHECK: ram_we = !is_test_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_addr_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == BK_FINISH && out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Probe datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				h_q         <= q_job.hash;
				is_test_q   <= q_job.is_test;
				all_set_q   <= 1'b1;
				probe_cnt_q <= '0;
			end
			BK_HASH: begin
				dvd_q <= h_next ^ (h_next >> 16);
				rem_q <= '0;
				bit_q <= '0;
			end
			BK_DIV: begin
				rem_q <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
				dvd_q <= dvd_q << 1;
				bit_q <= bit_q + 1'b1;
			end
			BK_CHECK: begin
				// The next probe starts from this probe's bit index
				h_q         <= HASH_W'(rem_q);
				all_set_q   <= all_set_q && probe_bit;
				probe_cnt_q <= probe_cnt_q + 1'b1;
			end
			BK_FINISH: begin
				if (out_load) answer_q <= is_test_q ? all_set_q : !all_set_q;
			end
			default: begin
			end
		endcase
	end

	assign status.clearing = (state_q == BK_CLEAR);
	assign m_tvalid        = m_tvalid_q;
	assign answer          = answer_q;

endmodule

// ----- rtl/core/bloom_filter_add_test.sv -----
// Bloom filter with add and test. A value streams in one byte per word on the
// slave side; s_tlast marks its final word and s_tuser on that word picks the
// operation (0 add, 1 test). Bytes fold into a 32-bit hash at one word per
// cycle while s_tready is high. On the last word the hash is queued (two
// entries) for the probe engine, which runs one probe at a time: it steps
// the hash, runs the bit-serial modulo by 8 * filter_bytes, then does a read
// and a read-modify-write of the bitmap RAM, and the answer then waits for
// the output register. One result word per value comes out on the master
// side, answer in m_tdata[0]: for add, 1 if some probed bit was new; for
// test, 1 if every probed bit was set. After reset the bitmap RAM is zeroed
// one byte per cycle while s_tready stays low. Configuration: cfg_we with
// cfg_index 0 writes num_probes from cfg_data[3:0] (values above 8 act as 8),
// index 1 writes filter_bytes (0 acts as 1, above 1024 as 1024).
// Write only while no value is in flight; writes never clear the bitmap.
module bloom_filter_add_test import bf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // [7:0] value_byte, [8] has_byte
	input  logic                  s_tuser,   // [0] func
	input  logic                  s_tlast,   // last_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [0] answer
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [PROBE_W-1:0] num_probes_q;
	logic [BYTES_W-1:0] filter_bytes_q;
	logic [BYTES_W-1:0] eff_bytes;
	bf_cfg_t            cfg;

	bf_status_t status;
	logic       push;
	bf_job_t    push_job;
	logic       q_ready;
	logic       q_valid;
	bf_job_t    pop_job;
	logic       pop;
	logic       answer;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_probes_q   <= PROBES_RESET;
			filter_bytes_q <= BYTES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_PROBES:   num_probes_q   <= cfg_data[PROBE_W-1:0];
				CFG_FILTER_BYTES: filter_bytes_q <= cfg_data[BYTES_W-1:0];
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// Clamp the size to 1..MAX_BYTES and the probe count to MAX_PROBES
	always_comb begin
		priority if (filter_bytes_q == '0) begin
			eff_bytes = BYTES_W'(1);
		end else if (filter_bytes_q > BYTES_W'(MAX_BYTES)) begin
			eff_bytes = BYTES_W'(MAX_BYTES);
		end else begin
			eff_bytes = filter_bytes_q;
		end
		cfg.probes = (num_probes_q > PROBE_W'(MAX_PROBES)) ? PROBE_W'(MAX_PROBES)
		                                                   : num_probes_q;
		cfg.range  = {eff_bytes[ADDR_W:0], 3'b000};
	end

	// Front: hash the bytes, queue a job per value
	bf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.value_byte (s_tdata[7:0]),
		.has_byte   (s_tdata[8]),
		.last_byte  (s_tlast),
		.func       (s_tuser),
		.status     (status),
		.q_ready    (q_ready),
		.push       (push),
		.job        (push_job)
	);

	// Hold finished hashes until the probe engine is free
	bf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.q_ready  (q_ready),
		.pop      (pop),
		.q_valid  (q_valid),
		.pop_job  (pop_job)
	);

	// Back: probe the bitmap and deliver the answer word
	bf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_job    (pop_job),
		.pop      (pop),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.answer   (answer)
	);

	assign m_tdata = {7'b0, answer};

	// No word enters while the bitmap is being zeroed
	assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !s_tready)
		else $error("word accepted during bitmap clear");

	// The front never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !q_ready))
		else $error("job queue overflow");

	// A last word leaves a job waiting for the back end
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> q_valid)
		else $error("job lost after last word");

	// The back end pops only when a job is present
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

// ----- tb/tb_bloom_filter_add_test.sv -----
`timescale 1ns / 100ps

module tb_bloom_filter_add_test;
	import bf_pkg::*;

	// Operation codes carried in s_tuser
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TEST = 1'b1;

	// Register indexes outside the list: writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

	// Drain wait, rounded up past the longest back-end run of MAX_PROBES probes
	localparam int DRAIN_CYCLES = 400;
	localparam int TOTAL_WORDS  = 1250;
	localparam int POOL_SIZE    = 32;

	// A value as sent: up to eight bytes, byte i in bytes[8*i +: 8]
	typedef struct packed {
		logic [3:0]  len;
		logic [63:0] bytes;
	} value_key_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata = '0;   // [7:0] value_byte, [8] has_byte
	logic                  s_tuser = 1'b0; // [0] func
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;        // [0] answer
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the filter: bitmap, running hash and the two registers
	logic [7:0]         bitmap_shadow [MAX_BYTES];
	logic [HASH_W-1:0]  hash_shadow;
	logic [PROBE_W-1:0] probes_shadow;
	logic [BYTES_W-1:0] bytes_shadow;

	logic       answers_due [$];  // expected answer bits, oldest first
	value_key_t added_keys [$];   // values recently added, reused for hits
	int         bad_words = 0;
	int         words_sent = 0;
	logic       src_quiet = 1'b0; // sender runs back to back when set
	logic       sink_quiet = 1'b0; // receiver never stalls when set

	bloom_filter_add_test DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Fold one accepted word into the shadow; on the last word run the probes
	// and queue the answer the block must return.
	task automatic hash_and_probe(input logic op, input logic [7:0] vb,
			input logic has, input logic last);
		logic [HASH_W-1:0] h;
		logic [31:0]       span;
		int                n_bytes;
		int                n_probes;
		logic              all_set;
		logic [9:0]        slot;
		if (has)
			hash_shadow = hash_shadow * 32'd31 + {{24{vb[7]}}, vb};
		if (!last)
			return;
		h = hash_shadow;
		hash_shadow = '0;
		// Clamp the registers the same way the block does
		n_bytes = (bytes_shadow == 0) ? 1 : int'(bytes_shadow);
		if (n_bytes > MAX_BYTES)
			n_bytes = MAX_BYTES;
		n_probes = (probes_shadow > MAX_PROBES) ? MAX_PROBES : int'(probes_shadow);
		span = n_bytes * 8;
		all_set = 1'b1;
		for (int i = 0; i < n_probes; i++) begin
			h = h * 32'd31 + PROBE_ADD;
			h = (h ^ (h >> 16)) % span;
			slot = h[12:3];
			if (!bitmap_shadow[slot][h[2:0]])
				all_set = 1'b0;
			if (op == OP_ADD)
				bitmap_shadow[slot][h[2:0]] = 1'b1;
		end
		answers_due.push_back((op == OP_TEST) ? all_set : !all_set);
	endtask

	// Send one word: idle for a drawn number of cycles, then hold it until taken.
	task automatic send_word(input logic op, input logic [7:0] vb,
			input logic has, input logic last);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, has, vb};
		s_tuser  <= op;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		hash_and_probe(op, vb, has, last);
		if (has || last)
			words_sent++;
	endtask

	// Send a whole value; only the last word's func selects the operation.
	task automatic send_value(input value_key_t k, input logic op);
		if (k.len == 0)
			send_word(op, 8'($urandom), 1'b0, 1'b1);
		else
			for (int i = 0; i < k.len; i++)
				send_word((i == k.len - 1) ? op : 1'($urandom_range(0, 1)),
					k.bytes[8*i +: 8], 1'b1, i == k.len - 1);
	endtask

	function automatic value_key_t make_key(input int len);
		value_key_t k;
		k.len = 4'(len);
		k.bytes = {$urandom, $urandom};
		return k;
	endfunction

	// Park the sender and wait until every answer is back and the probe engine
	// has had time to finish whatever it still holds.
	task automatic wait_for_drain();
		@(negedge clk) s_tvalid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle and mirror it in the shadow.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wait_for_drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk) cfg_we <= 1'b0;
		case (idx)
			CFG_NUM_PROBES:   probes_shadow = data[PROBE_W-1:0];
			CFG_FILTER_BYTES: bytes_shadow = data[BYTES_W-1:0];
			default: ;
		endcase
	endtask

	// Default registers: byte extremes, repeat add, hit and empty value
	task automatic test_defaults();
		send_value('{len: 4'd1, bytes: 64'h00}, OP_ADD);
		send_value('{len: 4'd1, bytes: 64'h00}, OP_ADD);
		send_value('{len: 4'd1, bytes: 64'h00}, OP_TEST);
		send_value('{len: 4'd2, bytes: 64'h807F}, OP_TEST);
		send_value('{len: 4'd4, bytes: 64'h007F_80FF}, OP_ADD);
		send_value('{len: 4'd4, bytes: 64'h007F_80FF}, OP_TEST);
		send_value('{len: 4'd0, bytes: 64'h0}, OP_ADD);
		send_value('{len: 4'd0, bytes: 64'h0}, OP_TEST);
	endtask

	// Probe count: none, more than the limit (acts as the limit), the limit
	task automatic test_probe_count();
		write_reg(CFG_NUM_PROBES, 11'd0);
		send_value('{len: 4'd1, bytes: 64'h55}, OP_ADD);
		send_value('{len: 4'd1, bytes: 64'hAA}, OP_TEST);
		write_reg(CFG_NUM_PROBES, 11'h7FF);
		send_value('{len: 4'd1, bytes: 64'hAA}, OP_ADD);
		write_reg(CFG_NUM_PROBES, 11'(MAX_PROBES));
		send_value('{len: 4'd1, bytes: 64'hAA}, OP_TEST);
	endtask

	// Bitmap size: zero acts as one byte, oversize acts as the maximum, and
	// resizing must keep the bits already set.
	task automatic test_filter_size();
		write_reg(CFG_FILTER_BYTES, 11'd0);
		send_value('{len: 4'd1, bytes: 64'h01}, OP_ADD);
		send_value('{len: 4'd1, bytes: 64'h02}, OP_TEST);
		write_reg(CFG_FILTER_BYTES, 11'h7FF);
		send_value('{len: 4'd1, bytes: 64'h01}, OP_TEST);
		write_reg(CFG_FILTER_BYTES, 11'd1);
		send_value('{len: 4'd1, bytes: 64'h01}, OP_TEST);
		write_reg(CFG_FILTER_BYTES, 11'(MAX_BYTES));
		write_reg(CFG_NUM_PROBES, 11'd2);
		send_value('{len: 4'd1, bytes: 64'h00}, OP_TEST);
	endtask

	// Writes to indexes past the list must leave both registers alone
	task automatic test_bad_index();
		write_reg(CFG_UNUSED_A, 11'h7FF);
		write_reg(CFG_UNUSED_B, 11'h000);
		send_value('{len: 4'd4, bytes: 64'h007F_80FF}, OP_TEST);
	endtask

	// Byteless words in the middle of a value change nothing
	task automatic test_byteless_words();
		send_word(OP_TEST, 8'hC3, 1'b0, 1'b0);
		send_word(OP_ADD, 8'h12, 1'b1, 1'b0);
		send_word(OP_TEST, 8'h3C, 1'b0, 1'b0);
		send_word(OP_ADD, 8'h34, 1'b1, 1'b1);
		send_value('{len: 4'd2, bytes: 64'h3412}, OP_TEST);
	endtask

	// Random phases: fresh settings each phase, then mostly whole values built
	// around a pool of added keys so tests hit as well as miss, with some
	// byteless noise and dangling partial values mixed in.
	task automatic test_random_traffic();
		value_key_t k;
		int         pick;
		int         len;
		int         values_left;
		logic [3:0] probes;
		int         nbytes;
		while (words_sent < TOTAL_WORDS) begin
			pick = $urandom_range(0, 9);
			probes = (pick < 6) ? 4'($urandom_range(1, 4)) :
				(pick == 6) ? 4'd0 : (pick == 7) ? 4'(MAX_PROBES) : 4'($urandom);
			write_reg(CFG_NUM_PROBES, (11'($urandom) & 11'h7F0) | 11'(probes));
			pick = $urandom_range(0, 9);
			nbytes = (pick < 5) ? $urandom_range(1, 32) : (pick == 5) ? 0 :
				(pick == 6) ? MAX_BYTES : (pick == 7) ? 2047 : $urandom_range(0, 2047);
			write_reg(CFG_FILTER_BYTES, 11'(nbytes));
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
					11'($urandom));
			src_quiet  = ($urandom_range(0, 3) == 0);
			sink_quiet = ($urandom_range(0, 3) == 0);
			values_left = $urandom_range(20, 60);
			while (values_left > 0 && words_sent < TOTAL_WORDS) begin
				values_left--;
				pick = $urandom_range(0, 19);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) :
					$urandom_range(1, 5);
				if (pick == 0) begin
					// Noise: byteless words that the block must skip
					repeat ($urandom_range(1, 3))
						send_word(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b0);
				end else if (pick == 1) begin
					// Dangling bytes with no last mark: they prefix the next value
					repeat ($urandom_range(1, 2))
						send_word(1'($urandom_range(0, 1)), 8'($urandom), 1'b1, 1'b0);
				end
				if (pick < 10 || added_keys.size() == 0) begin
					k = make_key(len);
					if (pick < 7) begin
						send_value(k, OP_ADD);
						added_keys.push_back(k);
						if (added_keys.size() > POOL_SIZE)
							void'(added_keys.pop_front());
					end else
						send_value(k, OP_TEST);
				end else begin
					k = added_keys[$urandom_range(0, added_keys.size() - 1)];
					send_value(k, (pick < 17) ? OP_TEST : OP_ADD);
				end
				// Hold off now and then until the answers are all back
				if ($urandom_range(0, 29) == 0)
					wait_for_drain();
			end
		end
	endtask

	// Receiver: stall a drawn number of cycles, then take one word
	initial begin : result_sink
		int stall;
		forever begin
			stall = sink_quiet ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare each taken result word with the oldest expected answer
	always @(posedge clk) begin : check_answers
		logic due_answer;
		if (m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				$error("answer: expected none, actual %0d", m_tdata[0]);
				bad_words++;
			end else begin
				due_answer = answers_due.pop_front();
				if (m_tdata[0] !== due_answer) begin
					$error("answer: expected %0d, actual %0d", due_answer, m_tdata[0]);
					bad_words++;
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run, bitmap clearing included
	initial begin
		#(10_000_000);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		for (int i = 0; i < MAX_BYTES; i++)
			bitmap_shadow[i] = '0;
		hash_shadow   = '0;
		probes_shadow = PROBES_RESET;
		bytes_shadow  = BYTES_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_defaults();
		test_probe_count();
		test_filter_size();
		test_bad_index();
		test_byteless_words();
		test_random_traffic();

		wait_for_drain();
		if (answers_due.size() != 0) begin
			$error("answer: expected %0d more words, actual none", answers_due.size());
			bad_words++;
		end
		if (bad_words == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- bloom_filter_add_test.f -----
rtl/core/bf_pkg.sv
rtl/core/bf_ram.sv
rtl/core/bf_front.sv
rtl/core/bf_queue.sv
rtl/core/bf_back.sv
rtl/core/bloom_filter_add_test.sv
tb/tb_bloom_filter_add_test.sv
